// ===== sv/sector_cache_usage_count_replacement_top_macros.svh =====
// assertion helpers for the sector cache tag store
// each check is clocked on clk and held off while arst_n is low
`ifndef SECTOR_CACHE_USAGE_COUNT_REPLACEMENT_TOP_MACROS_SVH
`define SECTOR_CACHE_USAGE_COUNT_REPLACEMENT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SCUCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define SCUCR_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SCUCR_ASSERT(lbl, prop, msg)
`define SCUCR_NEVER(lbl, cond, msg)
`endif

`endif

// ===== sv/scucr_pkg.sv =====
package scucr_pkg;

	// default number of cache slots
	localparam int unsigned NUM_SLOTS_DEF = 16;

	// field widths
	localparam int unsigned OP_W     = 2;
	localparam int unsigned DRIVE_W  = 4;
	localparam int unsigned SECTOR_W = 32;
	localparam int unsigned SLOT_W   = 4;
	localparam int unsigned TAG_W    = DRIVE_W + SECTOR_W;

	// request op codes
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_INVAL  = 2'd2;

	// request beat
	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [DRIVE_W-1:0]  drive;
		logic [SECTOR_W-1:0] sector;
	} req_t;

	// response beat
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEARCH = 6'b000010,
		ST_FREE   = 6'b000100,
		ST_AGE    = 6'b001000,
		ST_FILL   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

endpackage

// ===== sv/sector_cache_usage_count_replacement_top.sv =====
// Tag store of a sector cache with usage-count replacement and aging. One request is
// handled at a time: req_ready is high only while the sequencer is idle, and the
// response sits in an output register so the next request can be taken while it waits.
// All slot tags and usage counts live in a single-read-port store that the sequencer
// walks one slot per cycle. A lookup or invalidate reads slots in index order from
// slot zero until it hits or passes the last slot. An add walks the valid bits from
// the scan pointer for a free slot; when every slot is valid it follows the full
// free-slot walk with an aging pass that picks the victim. An unused op code answers
// with found clear. No clearing pass is needed after reset.
`include "sector_cache_usage_count_replacement_top_macros.svh"

module sector_cache_usage_count_replacement_top #(
	parameter int unsigned NUM_SLOTS = scucr_pkg::NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  scucr_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output scucr_pkg::rsp_t   rsp
);
	import scucr_pkg::*;

	localparam int unsigned IW = $clog2(NUM_SLOTS);
	localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

	// low slot bits of an index, zero-extended for small stores
	function automatic logic [SLOT_W-1:0] slot_of(input logic [IW-1:0] i);
		logic [IW+SLOT_W-1:0] e;
		e = {{SLOT_W{1'b0}}, i};
		return e[SLOT_W-1:0];
	endfunction

	// wrapping slot increment
	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
		return (i == IW'(NUM_SLOTS - 1)) ? '0 : i + IW'(1);
	endfunction

	state_t              state_q, state_d;
	req_t                req_q, req_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [IW-1:0]       ptr_q, ptr_d;
	logic [IW-1:0]       scan_ptr_q, scan_d;
	logic [IW-1:0]       victim_q, victim_d;
	logic [IW-1:0]       cand_q, cand_d;
	logic [CW-1:0]       min_q, min_d;
	rsp_t                res_q, res_d;
	logic [NUM_SLOTS-1:0] valid_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	// read pipeline stage
	logic                rd_vld_s1, rd_vld_d;
	logic [IW-1:0]       rd_idx_s1;
	logic                rd_first_s1, first_d;
	logic                rd_last_s1, last_d;
	logic [TAG_W-1:0]    tag_rd_s1;
	logic [CW-1:0]       use_rd_s1;

	// store access controls
	logic                rd_en;
	logic [IW-1:0]       rd_addr;
	logic                use_we;
	logic [IW-1:0]       use_waddr;
	logic [CW-1:0]       use_wdata;
	logic                tag_we;
	logic                set_vld, clr_vld;
	logic                rsp_load;

	// compare logic for search and aging
	logic                hit, issue, age_less;
	logic [CW-1:0]       age_min;
	logic [IW-1:0]       age_cand;

	logic [TAG_W-1:0]    tag_mem [NUM_SLOTS];
	logic [CW-1:0]       use_mem [NUM_SLOTS];

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign hit      = rd_vld_s1 && valid_q[rd_idx_s1]
	                  && (tag_rd_s1 == {req_q.drive, req_q.sector});
	assign issue    = (cnt_q != CW'(NUM_SLOTS));
	assign age_less = (use_rd_s1 < min_q);
	assign age_min  = (rd_first_s1 || age_less) ? use_rd_s1 : min_q;
	assign age_cand = (rd_first_s1 || age_less) ? rd_idx_s1 : cand_q;

	// sequencer
	always_comb begin
		state_d   = state_q;
		req_d     = req_q;
		cnt_d     = cnt_q;
		ptr_d     = ptr_q;
		scan_d    = scan_ptr_q;
		victim_d  = victim_q;
		cand_d    = cand_q;
		min_d     = min_q;
		res_d     = res_q;
		rd_en     = 1'b0;
		rd_addr   = ptr_q;
		rd_vld_d  = 1'b0;
		first_d   = 1'b0;
		last_d    = 1'b0;
		use_we    = 1'b0;
		use_waddr = rd_idx_s1;
		use_wdata = '0;
		tag_we    = 1'b0;
		set_vld   = 1'b0;
		clr_vld   = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_d = req;
					cnt_d = '0;
					case (req.op)
						OP_LOOKUP, OP_INVAL: begin
							ptr_d   = '0;
							state_d = ST_SEARCH;
						end
						OP_ADD: begin
							ptr_d   = scan_ptr_q;
							state_d = ST_FREE;
						end
						default: begin
							res_d   = '0;
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				// issue one slot read per cycle in index order
				if (issue) begin
					rd_en    = 1'b1;
					ptr_d    = next_slot(ptr_q);
					cnt_d    = cnt_q + CW'(1);
					rd_vld_d = 1'b1;
					last_d   = (cnt_q == CW'(NUM_SLOTS - 1));
				end
				// check the slot read last cycle
				if (hit) begin
					res_d.found = 1'b1;
					res_d.slot  = slot_of(rd_idx_s1);
					if (req_q.op == OP_LOOKUP) begin
						use_we    = 1'b1;
						use_wdata = (use_rd_s1 < CW'(NUM_SLOTS)) ? use_rd_s1 + CW'(1)
						                                         : use_rd_s1;
					end else begin
						clr_vld = 1'b1;
					end
					rd_vld_d = 1'b0;
					state_d  = ST_DONE;
				end else if (rd_vld_s1 && rd_last_s1) begin
					res_d   = '0;
					state_d = ST_DONE;
				end
			end
			ST_FREE: begin
				// walk valid bits from the scan pointer for a free slot
				if (!valid_q[ptr_q]) begin
					victim_d = ptr_q;
					state_d  = ST_FILL;
				end else if (cnt_q == CW'(NUM_SLOTS - 1)) begin
					ptr_d   = scan_ptr_q;
					cnt_d   = '0;
					state_d = ST_AGE;
				end else begin
					ptr_d = next_slot(ptr_q);
					cnt_d = cnt_q + CW'(1);
				end
			end
			ST_AGE: begin
				// read counts from the scan pointer, wrapping
				if (issue) begin
					rd_en    = 1'b1;
					ptr_d    = next_slot(ptr_q);
					cnt_d    = cnt_q + CW'(1);
					rd_vld_d = 1'b1;
					first_d  = (cnt_q == '0);
					last_d   = (cnt_q == CW'(NUM_SLOTS - 1));
				end
				if (rd_vld_s1) begin
					if (rd_first_s1 && (use_rd_s1 <= CW'(1))) begin
						// pointer slot already little used: evict without aging
						victim_d = rd_idx_s1;
						rd_vld_d = 1'b0;
						state_d  = ST_FILL;
					end else begin
						// track minimum on the old count, then decrement
						min_d     = age_min;
						cand_d    = age_cand;
						use_we    = 1'b1;
						use_wdata = (use_rd_s1 == '0) ? '0 : use_rd_s1 - CW'(1);
						if ((age_min <= CW'(1)) || rd_last_s1) begin
							victim_d = age_cand;
							rd_vld_d = 1'b0;
							state_d  = ST_FILL;
						end
					end
				end
			end
			ST_FILL: begin
				// install the new tag with usage one
				tag_we      = 1'b1;
				set_vld     = 1'b1;
				use_we      = 1'b1;
				use_waddr   = victim_q;
				use_wdata   = CW'(1);
				scan_d      = victim_q;
				res_d.found = 1'b1;
				res_d.slot  = slot_of(victim_q);
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				// hand the result to the response register when it is free
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			scan_ptr_q  <= '0;
			valid_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			ptr_q      <= ptr_d;
			scan_ptr_q <= scan_d;
			rd_vld_s1  <= rd_vld_d;
			if (set_vld) begin
				valid_q[victim_q] <= 1'b1;
			end
			if (clr_vld) begin
				valid_q[rd_idx_s1] <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		req_q       <= req_d;
		victim_q    <= victim_d;
		cand_q      <= cand_d;
		min_q       <= min_d;
		res_q       <= res_d;
		rd_idx_s1   <= rd_addr;
		rd_first_s1 <= first_d;
		rd_last_s1  <= last_d;
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	// tag and usage store, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_rd_s1 <= tag_mem[rd_addr];
			use_rd_s1 <= use_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[victim_q] <= {req_q.drive, req_q.sector};
		end
		if (use_we) begin
			use_mem[use_waddr] <= use_wdata;
		end
	end

	// checks
	`SCUCR_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "request taken while busy")
	`SCUCR_ASSERT(a_age_all_valid, state_q == ST_AGE |-> &valid_q, "aging with a free slot")
	`SCUCR_ASSERT(a_done_holds, state_q == ST_DONE && rsp_valid_q && !rsp_ready |=> state_q == ST_DONE, "result dropped under stall")
	`SCUCR_NEVER(a_stale_read, rd_vld_s1 && state_q != ST_SEARCH && state_q != ST_AGE, "read data outside a walk")
	`SCUCR_NEVER(a_miss_slot_zero, rsp_valid_q && !rsp_q.found && rsp_q.slot != '0, "miss with nonzero slot")

endmodule
